>>> rtl/lmls_pkg.sv
// Shared types, timing constants and helpers for the LCD mode and line sequencer.
`default_nettype none

package lmls_pkg;

    // Line and mode timing.
    localparam int VISIBLE_LINES  = 144;
    localparam int TOTAL_LINES    = 154;
    localparam int SEARCH_TICKS   = 320;
    localparam int TRANSFER_TICKS = 688;
    localparam int HBLANK_TICKS_P = 816;
    localparam int LINE_TICKS     = SEARCH_TICKS + TRANSFER_TICKS + HBLANK_TICKS_P;

    // Field and datapath widths.
    localparam int TICK_W  = 8;
    localparam int ACC_W   = 11;
    localparam int SUM_W   = 12;
    localparam int LINE_W  = 8;
    localparam int LINEP_W = 9;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [ACC_W-1:0]   ACC_MAX         = {ACC_W{1'b1}};
    localparam logic [SUM_W-1:0]   SEARCH_DUR      = SUM_W'(SEARCH_TICKS);
    localparam logic [SUM_W-1:0]   TRANSFER_DUR    = SUM_W'(TRANSFER_TICKS);
    localparam logic [SUM_W-1:0]   HBLANK_DUR      = SUM_W'(HBLANK_TICKS_P);
    localparam logic [SUM_W-1:0]   LINE_DUR        = SUM_W'(LINE_TICKS);
    localparam logic [LINE_W-1:0]  VISIBLE_LINE_V  = LINE_W'(VISIBLE_LINES);
    localparam logic [LINEP_W-1:0] TOTAL_LINES_V   = LINEP_W'(TOTAL_LINES);

    // Mode codes as seen on the output port.
    localparam logic [MODE_W-1:0] LCD_MODE_HBLANK   = 2'd0;
    localparam logic [MODE_W-1:0] LCD_MODE_VBLANK   = 2'd1;
    localparam logic [MODE_W-1:0] LCD_MODE_SEARCH   = 2'd2;
    localparam logic [MODE_W-1:0] LCD_MODE_TRANSFER = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_IRQ_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VBL_IRQ_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRCH_IRQ_EN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_EN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPR_EN       = 3'd5;

    // Internal mode state, one-hot.
    typedef enum logic [3:0] {
        MODE_HBLANK   = 4'b0001,
        MODE_VBLANK   = 4'b0010,
        MODE_SEARCH   = 4'b0100,
        MODE_TRANSFER = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [LINE_W-1:0] line_compare;
        logic              coin_irq_en;
        logic              vbl_irq_en;
        logic              srch_irq_en;
        logic              bg_en;
        logic              spr_en;
    } t_cfg;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              match;
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              line_match;
        logic              vblank_irq;
        logic              stat_irq;
        logic              draw_background;
        logic              draw_sprites;
    } t_result;

    // Map the one-hot mode onto the two-bit port code.
    function automatic logic [MODE_W-1:0] lcd_code(input t_mode mode);
        logic [MODE_W-1:0] code;
        case (mode)
            MODE_HBLANK:   code = LCD_MODE_HBLANK;
            MODE_SEARCH:   code = LCD_MODE_SEARCH;
            MODE_TRANSFER: code = LCD_MODE_TRANSFER;
            default:       code = LCD_MODE_VBLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lmls_step.sv
// Next-state and result logic for one tick beat of the LCD sequencer.
`default_nettype none

module lmls_step (
    input  wire lmls_pkg::t_state                   i_state,
    input  wire lmls_pkg::t_cfg                     i_cfg,
    input  wire logic [lmls_pkg::TICK_W-1:0]        i_ticks,
    output lmls_pkg::t_state                        o_state,
    output lmls_pkg::t_result                       o_result
);

    always_comb begin
        logic [lmls_pkg::SUM_W-1:0]   sum;
        logic [lmls_pkg::SUM_W-1:0]   dur;
        logic [lmls_pkg::SUM_W-1:0]   acc_new;
        logic                         fire;
        logic [lmls_pkg::LINEP_W-1:0] line_inc;
        logic [lmls_pkg::LINEP_W-1:0] line_wrap;
        logic [lmls_pkg::LINE_W-1:0]  new_line;
        logic                         new_match;
        logic                         vbl;
        logic                         stat;
        logic                         dbg;
        logic                         dspr;

        sum = {1'b0, i_state.acc} + lmls_pkg::SUM_W'(i_ticks);

        case (i_state.mode)
            lmls_pkg::MODE_SEARCH:   dur = lmls_pkg::SEARCH_DUR;
            lmls_pkg::MODE_TRANSFER: dur = lmls_pkg::TRANSFER_DUR;
            lmls_pkg::MODE_HBLANK:   dur = lmls_pkg::HBLANK_DUR;
            default:                 dur = lmls_pkg::LINE_DUR;
        endcase

        fire    = (sum >= dur);
        acc_new = fire ? (sum - dur) : sum;

        // The vertical blank line count wraps at the total line count; the
        // incremented line never reaches twice that value.
        line_inc  = {1'b0, i_state.line} + lmls_pkg::LINEP_W'(1);
        line_wrap = (line_inc >= lmls_pkg::TOTAL_LINES_V) ?
                    (line_inc - lmls_pkg::TOTAL_LINES_V) : line_inc;

        new_line  = (i_state.mode == lmls_pkg::MODE_HBLANK) ? line_inc[lmls_pkg::LINE_W-1:0]
                                                            : line_wrap[lmls_pkg::LINE_W-1:0];
        new_match = (new_line == i_cfg.line_compare);

        o_state       = i_state;
        o_state.acc   = (acc_new > lmls_pkg::SUM_W'(lmls_pkg::ACC_MAX)) ?
                        lmls_pkg::ACC_MAX : acc_new[lmls_pkg::ACC_W-1:0];
        vbl  = 1'b0;
        stat = 1'b0;
        dbg  = 1'b0;
        dspr = 1'b0;

        if (fire) begin
            case (i_state.mode)
                lmls_pkg::MODE_SEARCH: begin
                    o_state.mode = lmls_pkg::MODE_TRANSFER;
                end
                lmls_pkg::MODE_TRANSFER: begin
                    o_state.mode = lmls_pkg::MODE_HBLANK;
                    dbg  = i_cfg.bg_en;
                    dspr = i_cfg.spr_en;
                end
                lmls_pkg::MODE_HBLANK: begin
                    o_state.line  = new_line;
                    o_state.match = new_match;
                    stat = i_cfg.coin_irq_en & new_match;
                    if (new_line == lmls_pkg::VISIBLE_LINE_V) begin
                        o_state.mode = lmls_pkg::MODE_VBLANK;
                        vbl  = 1'b1;
                        stat = stat | i_cfg.vbl_irq_en;
                    end else begin
                        o_state.mode = lmls_pkg::MODE_SEARCH;
                        stat = stat | i_cfg.srch_irq_en;
                    end
                end
                default: begin
                    o_state.line  = new_line;
                    o_state.match = new_match;
                    stat = i_cfg.coin_irq_en & new_match;
                    if (new_line == '0) begin
                        o_state.mode = lmls_pkg::MODE_SEARCH;
                        stat = stat | i_cfg.srch_irq_en;
                    end
                end
            endcase
        end

        o_result.lcd_mode        = lmls_pkg::lcd_code(o_state.mode);
        o_result.current_line    = o_state.line;
        o_result.line_match      = o_state.match;
        o_result.vblank_irq      = vbl;
        o_result.stat_irq        = stat;
        o_result.draw_background = dbg;
        o_result.draw_sprites    = dspr;
    end

endmodule

`default_nettype wire

>>> rtl/lmls_out_reg.sv
// Result register with valid/ready handshake for the LCD sequencer.
`default_nettype none

module lmls_out_reg (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_load,
    input  wire lmls_pkg::t_result    i_result,
    input  wire                       i_ready,
    output logic                      o_can_load,
    output logic                      o_valid,
    output lmls_pkg::t_result         o_result
);

    logic              r_valid;
    logic              n_valid;
    lmls_pkg::t_result r_result;

    // A new result may enter when the register is empty or being drained.
    assign o_can_load = !r_valid || i_ready;
    assign n_valid    = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/lcd_mode_line_sequencer.sv
// Top level of the LCD mode and line sequencer: registers, state and handshakes.
`default_nettype none

// Channel   Handshake                  Payload
// -------   -------------------------  ------------------------------------------
// in        i_in_valid / o_in_ready    i_elapsed_ticks
// out       o_out_valid / i_out_ready  o_lcd_mode, o_current_line, o_line_match,
//                                      o_vblank_irq, o_stat_irq,
//                                      o_draw_background, o_draw_sprites
// cfg       i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// Each beat waits in the input register until the result register has room;
// the step logic's result is then loaded into the result register and offered.
// A new beat is accepted every cycle while the output side does not stall;
// the mode/line/accumulator update for one beat is a single add, compare and
// subtract, done in the step logic. When the output side stalls, the input
// register holds one beat and then ready drops; nothing is lost. Reset is
// synchronous and active low and returns the sequencer to horizontal blank
// on line zero.

module lcd_mode_line_sequencer (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [lmls_pkg::TICK_W-1:0]          i_elapsed_ticks,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [lmls_pkg::MODE_W-1:0]          o_lcd_mode,
    output logic [lmls_pkg::LINE_W-1:0]          o_current_line,
    output logic                                 o_line_match,
    output logic                                 o_vblank_irq,
    output logic                                 o_stat_irq,
    output logic                                 o_draw_background,
    output logic                                 o_draw_sprites,
    input  wire                                  i_cfg_we,
    input  wire  [lmls_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [lmls_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers.
    lmls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_compare <= '0;
            r_cfg.coin_irq_en  <= 1'b0;
            r_cfg.vbl_irq_en   <= 1'b0;
            r_cfg.srch_irq_en  <= 1'b0;
            r_cfg.bg_en        <= 1'b1;
            r_cfg.spr_en       <= 1'b0;
        end else if (i_cfg_we) begin
            // Writes to indexes past the last register are dropped.
            case (i_cfg_idx)
                lmls_pkg::CFG_LINE_COMPARE: r_cfg.line_compare <= i_cfg_data;
                lmls_pkg::CFG_COIN_IRQ_EN:  r_cfg.coin_irq_en  <= i_cfg_data[0];
                lmls_pkg::CFG_VBL_IRQ_EN:   r_cfg.vbl_irq_en   <= i_cfg_data[0];
                lmls_pkg::CFG_SRCH_IRQ_EN:  r_cfg.srch_irq_en  <= i_cfg_data[0];
                lmls_pkg::CFG_BG_EN:        r_cfg.bg_en        <= i_cfg_data[0];
                lmls_pkg::CFG_SPR_EN:       r_cfg.spr_en       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: one beat of elapsed ticks waiting for the step logic.
    logic                          r_in_valid;
    logic [lmls_pkg::TICK_W-1:0]   r_in_ticks;
    logic                          in_take;
    logic                          advance;
    logic                          out_can_load;

    // The step fires when a beat is held and the result register has room.
    assign advance    = r_in_valid && out_can_load;
    assign o_in_ready = i_rst_n && (!r_in_valid || advance);
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ticks <= i_elapsed_ticks;
        end
    end

    // Sequencer state: tick accumulator, mode, line and coincidence flag.
    lmls_pkg::t_state  r_state;
    lmls_pkg::t_state  n_state;
    lmls_pkg::t_result step_result;
    lmls_pkg::t_result out_result;

    lmls_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_ticks  (r_in_ticks),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc   <= '0;
            r_state.mode  <= lmls_pkg::MODE_HBLANK;
            r_state.line  <= '0;
            r_state.match <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    lmls_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (step_result),
        .i_ready    (i_out_ready),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .o_result   (out_result)
    );

    assign o_lcd_mode        = out_result.lcd_mode;
    assign o_current_line    = out_result.current_line;
    assign o_line_match      = out_result.line_match;
    assign o_vblank_irq      = out_result.vblank_irq;
    assign o_stat_irq        = out_result.stat_irq;
    assign o_draw_background = out_result.draw_background;
    assign o_draw_sprites    = out_result.draw_sprites;

endmodule

`default_nettype wire

>>> rtl/lmls_checker.sv
// Port-level checks for the LCD sequencer, bound onto the top level.
`default_nettype none

module lmls_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  o_out_valid,
    input  wire                                  i_out_ready,
    input  wire  [lmls_pkg::MODE_W-1:0]          o_lcd_mode,
    input  wire  [lmls_pkg::LINE_W-1:0]          o_current_line,
    input  wire                                  o_vblank_irq,
    input  wire                                  o_stat_irq,
    input  wire                                  o_draw_background,
    input  wire                                  o_draw_sprites
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_lcd_mode) && $stable(o_current_line) && $stable(o_stat_irq))
        else $error("result payload changed while stalled");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_current_line} < lmls_pkg::TOTAL_LINES_V))
        else $error("line counter beyond total line count");

    a_vblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vblank_irq |->
            (o_lcd_mode == lmls_pkg::LCD_MODE_VBLANK) &&
            (o_current_line == lmls_pkg::VISIBLE_LINE_V))
        else $error("vblank interrupt outside vblank entry");

    a_draw_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_draw_background || o_draw_sprites) |->
            (o_lcd_mode == lmls_pkg::LCD_MODE_HBLANK) && !o_vblank_irq)
        else $error("draw strobe without end of transfer");

endmodule

bind lcd_mode_line_sequencer lmls_checker u_lmls_checker (.*);

`default_nettype wire

>>> dv/tb_lcd_mode_line_sequencer.sv
// Self-checking testbench for the LCD mode and line sequencer.
`timescale 1ns / 1ps

module tb_lcd_mode_line_sequencer;
    import lmls_pkg::*;

    // The result register is loaded once an accepted input beat is held and it has room.
    localparam int RESULT_LATENCY = 1;
    // Beats of random stimulus, and a hard ceiling in case the frame never wraps.
    localparam int RANDOM_BEATS = 1200;
    localparam int RANDOM_CAP   = 5000;
    // Random beats between two reprogramming points.
    localparam int PHASE_BEATS  = 250;
    // The receiver holds off once for a long stretch at this result count.
    localparam int HOLD_AT      = 350;
    localparam int HOLD_CYCLES  = 80;
    // Cycles in which no beat moves on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;

    // Register setups used by program_phase.
    localparam int SETUP_DIRECTED = -1;
    localparam int SETUP_ALL_OFF  = 0;
    localparam int SETUP_ALL_ON   = 1;

    // Row kinds of the directed table.
    localparam logic CHECK_TYPED     = 1'b1;
    localparam logic CHECK_PREDICTED = 1'b0;

    // One row of the directed table: the tick count of the beat and, for the rows
    // whose outcome is obvious, the status that the block must report.
    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic              typed;
        t_result           want;
    } t_tick_row;

    // Pulse bits in the rows below are ordered: match, vblank, stat, background, sprites.
    // The registers during this part: compare line 1, coincidence and search stat
    // interrupts on, vblank stat interrupt off, both draw strobes on.
    t_tick_row tick_script [22] = '{
        {8'd0,   CHECK_TYPED,     LCD_MODE_HBLANK,   8'd0, 5'b00000}, // idle tick after reset
        {8'd255, CHECK_TYPED,     LCD_MODE_HBLANK,   8'd0, 5'b00000}, // largest tick count
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        // Exactly the hblank length: line 1 matches the compare value, so the
        // coincidence and the search entry both ask for a stat interrupt.
        {8'd51,  CHECK_TYPED,     LCD_MODE_SEARCH,   8'd1, 5'b10100},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd64,  CHECK_TYPED,     LCD_MODE_SEARCH,   8'd1, 5'b10000}, // one tick short
        {8'd1,   CHECK_TYPED,     LCD_MODE_TRANSFER, 8'd1, 5'b10000}, // search ends
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd177, CHECK_TYPED,     LCD_MODE_TRANSFER, 8'd1, 5'b10000}, // one tick short
        {8'd1,   CHECK_TYPED,     LCD_MODE_HBLANK,   8'd1, 5'b10011}, // both draw strobes
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd50,  CHECK_TYPED,     LCD_MODE_HBLANK,   8'd1, 5'b10000}, // one tick short
        // Overshoot into line 2: the match clears, the search stat pulse stays.
        {8'd255, CHECK_TYPED,     LCD_MODE_SEARCH,   8'd2, 5'b00100},
        {8'd66,  CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd255, CHECK_PREDICTED, 15'd0},
        {8'd0,   CHECK_PREDICTED, 15'd0}
    };

    // Every input of the block has a known value from time zero.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [TICK_W-1:0] in_ticks  = '0;
    logic              out_ready = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wire                in_ready;
    wire                out_valid;
    wire [MODE_W-1:0]   lcd_mode;
    wire [LINE_W-1:0]   current_line;
    wire                line_match;
    wire                vblank_irq;
    wire                stat_irq;
    wire                draw_background;
    wire                draw_sprites;

    // Shadow of the configuration registers, at their reset values.
    t_cfg lcd_regs = {8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    // Shadow of the timing state, at its reset values.
    logic [ACC_W-1:0]  tick_acc  = '0;
    logic [MODE_W-1:0] mode_now  = LCD_MODE_HBLANK;
    logic [LINE_W-1:0] line_now  = '0;
    logic              match_now = 1'b0;
    // Number of times the frame has wrapped from the last vblank line to line 0.
    int frames_done = 0;

    // Status expected from the block, oldest first.
    t_result expected_status [$];

    int beats_offered = 0;
    int results_seen  = 0;
    int mismatches    = 0;

    lcd_mode_line_sequencer dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_elapsed_ticks   (in_ticks),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_lcd_mode        (lcd_mode),
        .o_current_line    (current_line),
        .o_line_match      (line_match),
        .o_vblank_irq      (vblank_irq),
        .o_stat_irq        (stat_irq),
        .o_draw_background (draw_background),
        .o_draw_sprites    (draw_sprites),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Advance the shadow timing state by one beat and return the status the block
    // must report for it. At most one mode change happens per beat; a beat that
    // overshoots a mode boundary carries the excess into the next mode.
    function automatic t_result advance_lcd_timing(input logic [TICK_W-1:0] ticks);
        logic [SUM_W-1:0]   sum;
        logic [LINEP_W-1:0] next_line;
        t_result            status;
        sum    = SUM_W'(tick_acc) + SUM_W'(ticks);
        status = '0;
        case (mode_now)
            LCD_MODE_SEARCH: begin
                if (sum >= SEARCH_DUR) begin
                    sum      = sum - SEARCH_DUR;
                    mode_now = LCD_MODE_TRANSFER;
                end
            end
            LCD_MODE_TRANSFER: begin
                if (sum >= TRANSFER_DUR) begin
                    sum                    = sum - TRANSFER_DUR;
                    status.draw_background = lcd_regs.bg_en;
                    status.draw_sprites    = lcd_regs.spr_en;
                    mode_now               = LCD_MODE_HBLANK;
                end
            end
            LCD_MODE_HBLANK: begin
                if (sum >= HBLANK_DUR) begin
                    sum             = sum - HBLANK_DUR;
                    line_now        = line_now + 1'b1;
                    match_now       = (line_now == lcd_regs.line_compare);
                    status.stat_irq = lcd_regs.coin_irq_en & match_now;
                    // The line after the last visible one opens the vertical blank.
                    if (line_now == VISIBLE_LINE_V) begin
                        mode_now          = LCD_MODE_VBLANK;
                        status.vblank_irq = 1'b1;
                        if (lcd_regs.vbl_irq_en) status.stat_irq = 1'b1;
                    end else begin
                        mode_now = LCD_MODE_SEARCH;
                        if (lcd_regs.srch_irq_en) status.stat_irq = 1'b1;
                    end
                end
            end
            default: begin
                // Each vblank line lasts as long as a whole visible line.
                if (sum >= LINE_DUR) begin
                    sum             = sum - LINE_DUR;
                    next_line       = LINEP_W'(line_now) + 1'b1;
                    line_now        = (next_line == TOTAL_LINES_V) ? '0 : next_line[LINE_W-1:0];
                    match_now       = (line_now == lcd_regs.line_compare);
                    status.stat_irq = lcd_regs.coin_irq_en & match_now;
                    if (line_now == '0) begin
                        mode_now    = LCD_MODE_SEARCH;
                        frames_done = frames_done + 1;
                        if (lcd_regs.srch_irq_en) status.stat_irq = 1'b1;
                    end
                end
            end
        endcase
        tick_acc = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];

        status.lcd_mode     = mode_now;
        status.current_line = line_now;
        status.line_match   = match_now;
        return status;
    endfunction

    // Tick counts for the random part. Most beats are large so that the run gets
    // through the visible lines, the vertical blank and the wrap to line 0; the
    // rest are the extremes 0 and 255 and counts drawn from the whole range.
    function automatic logic [TICK_W-1:0] draw_ticks();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        if (pick < 10) return '1;
        if (pick < 85) return TICK_W'($urandom_range(160, 255));
        return TICK_W'($urandom_range(0, 255));
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Write all eight register indexes back to back; the two spare indexes must be
    // ignored by the block. Write enable stays high over the whole burst.
    task automatic program_phase(input int setup);
        logic [CFG_DATA_W-1:0] image [8];
        int                    pick;
        case (setup)
            SETUP_DIRECTED: image = '{8'd1, 8'h01, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00};
            SETUP_ALL_OFF:  image = '{8'd0, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'hFF};
            SETUP_ALL_ON:   image = '{8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA, 8'h55};
            default: begin
                foreach (image[i]) image[i] = CFG_DATA_W'($urandom_range(0, 255));
                // Keep the compare value on a line that exists most of the time.
                pick = $urandom_range(0, 9);
                if (pick == 0)      image[CFG_LINE_COMPARE] = 8'd255;
                else if (pick == 1) image[CFG_LINE_COMPARE] = VISIBLE_LINE_V;
                else if (pick == 2) image[CFG_LINE_COMPARE] = 8'(TOTAL_LINES - 1);
                else                image[CFG_LINE_COMPARE] = 8'($urandom_range(0, 153));
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= image[i];
            @(posedge clk);
            // Single-bit registers take bit 0 of the data.
            case (CFG_IDX_W'(i))
                CFG_LINE_COMPARE: lcd_regs.line_compare = image[i];
                CFG_COIN_IRQ_EN:  lcd_regs.coin_irq_en  = image[i][0];
                CFG_VBL_IRQ_EN:   lcd_regs.vbl_irq_en   = image[i][0];
                CFG_SRCH_IRQ_EN:  lcd_regs.srch_irq_en  = image[i][0];
                CFG_BG_EN:        lcd_regs.bg_en        = image[i][0];
                CFG_SPR_EN:       lcd_regs.spr_en       = image[i][0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one beat after a random gap and hold it until the block takes it.
    // Every third stretch of 40 beats goes out back to back.
    task automatic offer_ticks(input logic [TICK_W-1:0] ticks, input logic typed,
                               input t_result want);
        int      gap;
        t_result predicted;
        gap = ((beats_offered / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ticks <= ticks;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // The beat was taken at this edge; the shadow state moves with it.
        predicted = advance_lcd_timing(ticks);
        expected_status.push_back(typed ? want : predicted);
        beats_offered = beats_offered + 1;
    endtask

    // Stimulus: reset, a directed walk through one line, then random beats in
    // phases with the registers reprogrammed while the block is idle.
    initial begin
        int n;
        int setup;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        program_phase(SETUP_DIRECTED);
        foreach (tick_script[i])
            offer_ticks(tick_script[i].ticks, tick_script[i].typed, tick_script[i].want);

        n     = 0;
        setup = SETUP_ALL_OFF;
        while ((n < RANDOM_BEATS || frames_done == 0) && n < RANDOM_CAP) begin
            if (n % PHASE_BEATS == 0) begin
                // Stop sending and let every outstanding status come back before
                // touching the registers.
                in_valid <= 1'b0;
                while (expected_status.size() != 0) @(posedge clk);
                program_phase(setup);
                setup = setup + 1;
            end
            offer_ticks(draw_ticks(), CHECK_PREDICTED, '0);
            n = n + 1;
        end
        in_valid <= 1'b0;

        // Drain, then let the pipeline run on so that any stray beat shows.
        while (expected_status.size() != 0) @(posedge clk);
        repeat (4 * RESULT_LATENCY) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: random stalls per beat, every third stretch of 50 beats without any,
    // and one long hold-off that lets the block fill up and drop its input ready.
    initial begin
        int      stall;
        t_result want;
        while (!rst_n) @(posedge clk);
        forever begin
            if (results_seen == HOLD_AT)              stall = HOLD_CYCLES;
            else if ((results_seen / 50) % 3 == 1)    stall = 0;
            else                                      stall = $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            // A status beat was taken at this edge.
            if (expected_status.size() == 0) begin
                mismatches = mismatches + 1;
                $display("%0t: status beat with nothing expected, mode %0d line %0d",
                         $time, lcd_mode, current_line);
            end else begin
                want = expected_status.pop_front();
                compare_field("lcd_mode",        want.lcd_mode,        lcd_mode);
                compare_field("current_line",    want.current_line,    current_line);
                compare_field("line_match",      want.line_match,      line_match);
                compare_field("vblank_irq",      want.vblank_irq,      vblank_irq);
                compare_field("stat_irq",        want.stat_irq,        stat_irq);
                compare_field("draw_background", want.draw_background, draw_background);
                compare_field("draw_sprites",    want.draw_sprites,    draw_sprites);
            end
            results_seen = results_seen + 1;
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves a beat means
    // the block is hung or has dropped a status beat.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
                idle_cycles = idle_cycles + 1;
            else
                idle_cycles = 0;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> lcd_mode_line_sequencer.f
rtl/lmls_pkg.sv
rtl/lmls_step.sv
rtl/lmls_out_reg.sv
rtl/lcd_mode_line_sequencer.sv
rtl/lmls_checker.sv
dv/tb_lcd_mode_line_sequencer.sv
